FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by rank_morphology_filter_3x3 to check itself
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// implication with the consequent delayed by ##n
`define ASSERT_DELAYED(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("assertion failed: delayed implication");

`endif

FILE: src/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Types, codes and compare helpers of the 3x3 rank / morphology filter
// ----------------------------------------------------------------------------
package rmf_pkg;

  // pixel width and derived sizes
  localparam int PIXEL_BITS = 16;
  localparam int SUM_BITS   = PIXEL_BITS + 3;
  localparam int PORT_BITS  = 16;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [8:0]            win_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  localparam pix_t PIX_MAX = {PIXEL_BITS{1'b1}};
  localparam int   CENTRE  = 4;

  // filter modes
  localparam logic [2:0] MODE_MIN     = 3'd0;
  localparam logic [2:0] MODE_MAX     = 3'd1;
  localparam logic [2:0] MODE_MEDIAN  = 3'd2;
  localparam logic [2:0] MODE_DEFLATE = 3'd3;
  localparam logic [2:0] MODE_INFLATE = 3'd4;

  // register indexes
  localparam logic [1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_STENCIL     = 2'd2;
  localparam logic [1:0] REG_MAX_VALUE   = 2'd3;

  // configuration seen by the merge stage
  typedef struct packed {
    logic [2:0]           mode;
    logic [PORT_BITS-1:0] threshold;
    logic [PORT_BITS-1:0] max_value;
  } cfg_t;

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return pmin(pmin(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return pmax(pmax(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return pmax(pmin(a, b), pmin(pmax(a, b), c));
  endfunction

endpackage

FILE: src/rmf_minmax_lane.sv
// ----------------------------------------------------------------------------
// rmf_minmax_lane
// Minimum and maximum over the centre and the stencil-selected neighbours
// ----------------------------------------------------------------------------
module rmf_minmax_lane (
  input  logic            clk,
  input  rmf_pkg::win_t   win,
  input  logic [7:0]      stencil,
  output rmf_pkg::pix_t   min_pix,
  output rmf_pkg::pix_t   max_pix
);

  rmf_pkg::pix_t nb [8];
  rmf_pkg::pix_t centre;
  rmf_pkg::pix_t min_a, min_b, max_a, max_b, centre_q;

  // neighbours left out of the stencil stand in as the centre
  always_comb begin
    centre = win[rmf_pkg::CENTRE];
    for (int k = 0; k < 8; k++) begin
      if (stencil[k]) begin
        nb[k] = (k < rmf_pkg::CENTRE) ? win[k] : win[k+1];
      end else begin
        nb[k] = centre;
      end
    end
  end

  // first level: two groups of four
  always_ff @(posedge clk) begin
    min_a    <= rmf_pkg::pmin(rmf_pkg::pmin(nb[0], nb[1]), rmf_pkg::pmin(nb[2], nb[3]));
    min_b    <= rmf_pkg::pmin(rmf_pkg::pmin(nb[4], nb[5]), rmf_pkg::pmin(nb[6], nb[7]));
    max_a    <= rmf_pkg::pmax(rmf_pkg::pmax(nb[0], nb[1]), rmf_pkg::pmax(nb[2], nb[3]));
    max_b    <= rmf_pkg::pmax(rmf_pkg::pmax(nb[4], nb[5]), rmf_pkg::pmax(nb[6], nb[7]));
    centre_q <= centre;
  end

  // second level: fold in the centre
  always_ff @(posedge clk) begin
    min_pix <= rmf_pkg::min3(min_a, min_b, centre_q);
    max_pix <= rmf_pkg::max3(max_a, max_b, centre_q);
  end

endmodule

FILE: src/rmf_median_lane.sv
// ----------------------------------------------------------------------------
// rmf_median_lane
// Median of nine: row sort, then max of mins, median of medians, min of maxes
// ----------------------------------------------------------------------------
module rmf_median_lane (
  input  logic            clk,
  input  rmf_pkg::win_t   win,
  output rmf_pkg::pix_t   med_pix
);

  rmf_pkg::pix_t row_lo  [3];
  rmf_pkg::pix_t row_mid [3];
  rmf_pkg::pix_t row_hi  [3];

  // sort each row of three
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      row_lo[r]  <= rmf_pkg::min3(win[3*r], win[3*r+1], win[3*r+2]);
      row_mid[r] <= rmf_pkg::med3(win[3*r], win[3*r+1], win[3*r+2]);
      row_hi[r]  <= rmf_pkg::max3(win[3*r], win[3*r+1], win[3*r+2]);
    end
  end

  // median of the three column candidates
  always_ff @(posedge clk) begin
    med_pix <= rmf_pkg::med3(
      rmf_pkg::max3(row_lo[0], row_lo[1], row_lo[2]),
      rmf_pkg::med3(row_mid[0], row_mid[1], row_mid[2]),
      rmf_pkg::min3(row_hi[0], row_hi[1], row_hi[2]));
  end

endmodule

FILE: src/rmf_mean_lane.sv
// ----------------------------------------------------------------------------
// rmf_mean_lane
// Rounded mean of the eight neighbours
// ----------------------------------------------------------------------------
module rmf_mean_lane (
  input  logic            clk,
  input  rmf_pkg::win_t   win,
  output rmf_pkg::pix_t   mean_pix
);

  localparam rmf_pkg::sum_t ROUND = rmf_pkg::sum_t'(4);

  rmf_pkg::sum_t ext [9];
  rmf_pkg::sum_t sum_a, sum_b, total;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ext[i] = rmf_pkg::sum_t'(win[i]);
    end
  end

  // two partial sums, rounding term in the first
  always_ff @(posedge clk) begin
    sum_a <= ext[0] + ext[1] + ext[2] + ext[3] + ROUND;
    sum_b <= ext[5] + ext[6] + ext[7] + ext[8];
  end

  // divide by eight
  always_comb begin
    total = sum_a + sum_b;
  end

  always_ff @(posedge clk) begin
    mean_pix <= total[rmf_pkg::SUM_BITS-1:3];
  end

endmodule

FILE: src/rmf_merge.sv
// ----------------------------------------------------------------------------
// rmf_merge
// Picks a lane by mode, limits change from centre (not median), clamps to max
// ----------------------------------------------------------------------------
module rmf_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  input  rmf_pkg::cfg_t                  cfg,
  input  rmf_pkg::pix_t                  centre,
  input  rmf_pkg::pix_t                  min_pix,
  input  rmf_pkg::pix_t                  max_pix,
  input  rmf_pkg::pix_t                  med_pix,
  input  rmf_pkg::pix_t                  mean_pix,
  output logic                           done,
  output logic [rmf_pkg::PORT_BITS-1:0]  filtered_pixel
);

  rmf_pkg::pix_t                  thr;
  rmf_pkg::pix_t                  lo;
  logic [rmf_pkg::PIXEL_BITS:0]   hi;
  rmf_pkg::pix_t                  hi_cap;
  rmf_pkg::pix_t                  val;
  rmf_pkg::pix_t                  max_cap;
  rmf_pkg::pix_t                  result;

  // change limits around the centre
  always_comb begin
    if (cfg.threshold > rmf_pkg::PORT_BITS'(rmf_pkg::PIX_MAX)) begin
      thr = rmf_pkg::PIX_MAX;
    end else begin
      thr = cfg.threshold[rmf_pkg::PIXEL_BITS-1:0];
    end
    lo     = (centre > thr) ? (centre - thr) : '0;
    hi     = {1'b0, centre} + {1'b0, thr};
    hi_cap = hi[rmf_pkg::PIXEL_BITS] ? rmf_pkg::PIX_MAX : hi[rmf_pkg::PIXEL_BITS-1:0];
  end

  // mode select
  always_comb begin
    unique case (cfg.mode)
      rmf_pkg::MODE_MIN:     val = rmf_pkg::pmax(min_pix, lo);
      rmf_pkg::MODE_MAX:     val = rmf_pkg::pmin(max_pix, hi_cap);
      rmf_pkg::MODE_MEDIAN:  val = med_pix;
      rmf_pkg::MODE_DEFLATE: val = rmf_pkg::pmax(rmf_pkg::pmin(mean_pix, centre), lo);
      rmf_pkg::MODE_INFLATE: val = rmf_pkg::pmin(rmf_pkg::pmax(mean_pix, centre), hi_cap);
      default:               val = centre;
    endcase
  end

  // clamp to max_value
  always_comb begin
    if (cfg.max_value > rmf_pkg::PORT_BITS'(rmf_pkg::PIX_MAX)) begin
      max_cap = rmf_pkg::PIX_MAX;
    end else begin
      max_cap = cfg.max_value[rmf_pkg::PIXEL_BITS-1:0];
    end
    result = rmf_pkg::pmin(val, max_cap);
  end

  // output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    filtered_pixel <= rmf_pkg::PORT_BITS'(result);
  end

endmodule

FILE: src/rank_morphology_filter_3x3.sv
// ----------------------------------------------------------------------------
// rank_morphology_filter_3x3
// 3x3 min / max / median / deflate / inflate filter, one window per clock
// ----------------------------------------------------------------------------
//  channel   signals                          direction  handshake
//  window    start, busy, nine pixel ports    in         start & !busy
//  result    done, filtered_pixel             out        done, one cycle
//  config    cfg_write, cfg_index, cfg_data   in         cfg_write
//
//  A window is taken every clock; busy stays low.
//  The done beat follows the accepting edge through the two register levels
//  of the lanes and the merge output register.
//  rst is synchronous: it clears the pipeline valids and loads the register
//  defaults (median mode, no change limit, full stencil, full clamp).
//  The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rank_morphology_filter_3x3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] top_left,
  input  logic [15:0] top_mid,
  input  logic [15:0] top_right,
  input  logic [15:0] mid_left,
  input  logic [15:0] centre_pixel,
  input  logic [15:0] mid_right,
  input  logic [15:0] bottom_left,
  input  logic [15:0] bottom_mid,
  input  logic [15:0] bottom_right,
  output logic        done,
  output logic [15:0] filtered_pixel,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PB = rmf_pkg::PIXEL_BITS;

  logic [2:0]    filter_mode;
  logic [15:0]   change_threshold;
  logic [7:0]    neighbour_stencil;
  logic [15:0]   max_value;

  rmf_pkg::win_t win;
  rmf_pkg::cfg_t cfg;
  rmf_pkg::pix_t centre_d1, centre_d2;
  rmf_pkg::pix_t min_pix, max_pix, med_pix, mean_pix;
  logic          valid_d1, valid_d2;
  logic          accept;

  // every window is taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode       <= rmf_pkg::MODE_MEDIAN;
      change_threshold  <= 16'hFFFF;
      neighbour_stencil <= 8'hFF;
      max_value         <= 16'hFFFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rmf_pkg::REG_FILTER_MODE: filter_mode       <= cfg_data[2:0];
        rmf_pkg::REG_THRESHOLD:   change_threshold  <= cfg_data;
        rmf_pkg::REG_STENCIL:     neighbour_stencil <= cfg_data[7:0];
        rmf_pkg::REG_MAX_VALUE:   max_value         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // window in raster order, low pixel bits only
  assign win[0] = top_left[PB-1:0];
  assign win[1] = top_mid[PB-1:0];
  assign win[2] = top_right[PB-1:0];
  assign win[3] = mid_left[PB-1:0];
  assign win[4] = centre_pixel[PB-1:0];
  assign win[5] = mid_right[PB-1:0];
  assign win[6] = bottom_left[PB-1:0];
  assign win[7] = bottom_mid[PB-1:0];
  assign win[8] = bottom_right[PB-1:0];

  assign cfg.mode      = filter_mode;
  assign cfg.threshold = change_threshold;
  assign cfg.max_value = max_value;

  // valid and centre follow the two lane levels
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d1 <= 1'b0;
      valid_d2 <= 1'b0;
    end else begin
      valid_d1 <= accept;
      valid_d2 <= valid_d1;
    end
  end

  always_ff @(posedge clk) begin
    centre_d1 <= win[rmf_pkg::CENTRE];
    centre_d2 <= centre_d1;
  end

  // lanes
  rmf_minmax_lane u_minmax (
    .clk     (clk),
    .win     (win),
    .stencil (neighbour_stencil),
    .min_pix (min_pix),
    .max_pix (max_pix)
  );

  rmf_median_lane u_median (
    .clk     (clk),
    .win     (win),
    .med_pix (med_pix)
  );

  rmf_mean_lane u_mean (
    .clk      (clk),
    .win      (win),
    .mean_pix (mean_pix)
  );

  // merge and output register
  rmf_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .valid          (valid_d2),
    .cfg            (cfg),
    .centre         (centre_d2),
    .min_pix        (min_pix),
    .max_pix        (max_pix),
    .med_pix        (med_pix),
    .mean_pix       (mean_pix),
    .done           (done),
    .filtered_pixel (filtered_pixel)
  );

  // an accepted window gives its done beat after the pipeline registers
  `ASSERT_DELAYED(a_accept_gives_done, accept, 3, done)

  // the pipeline valids line up with the done beat
  `ASSERT_IMPLIES(a_done_from_pipe, done, $past(valid_d2) && $past(valid_d1, 2))

endmodule
